// File: hdl/fln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fln_pkg;

	// Name positions never exceed 255, so one byte covers every store size
	typedef logic [7:0] pos_t;

	localparam int CHARS_PER_ENTRY = 13;

	// Byte offsets of the low character bytes inside a long-name entry
	localparam logic [4:0] CHAR_OFFSETS [CHARS_PER_ENTRY] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
	};

	// Result kinds
	localparam logic [1:0] KIND_LONG  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_CHAR  = 2'd3;

	// Directory byte codes
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] MARK_FREE    = 8'h00;
	localparam logic [7:0] MARK_DELETED = 8'hE5;
	localparam logic [3:0] ATTR_LFN     = 4'hF;
	localparam logic [2:0] SEQ_START    = 3'b010;

	// Entry layout
	localparam logic [4:0] ENTRY_LAST       = 5'd31;
	localparam logic [4:0] POS_ATTR         = 5'd11;
	localparam logic [4:0] POS_CHECKSUM     = 5'd13;
	localparam logic [4:0] POS_SIZE0        = 5'd28;
	localparam logic [4:0] POS_SIZE1        = 5'd29;
	localparam logic [4:0] POS_SIZE2        = 5'd30;
	localparam logic [4:0] POS_EXT          = 5'd8;
	localparam logic [4:0] POS_SHORT_LAST   = 5'd10;
	localparam logic [3:0] SHORT_NAME_BYTES = 4'd11;
	localparam logic [3:0] SHORT_EXT_START  = 4'd8;
	localparam logic [3:0] SHORT_MAX_LEN    = 4'd12;

	// Name-store engine operations
	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_LONG,
		ENG_MOVE,
		ENG_SHORT
	} eng_state_t;

	typedef struct packed {
		logic       go;
		eng_state_t op;
		logic       bank;
		pos_t       base;
		pos_t       count;
		logic       dot;
		logic [3:0] dot_pos;
	} eng_job_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
	} ent_rd_t;

	typedef struct packed {
		logic en;
		pos_t addr;
	} name_rd_t;

	typedef struct packed {
		logic       en;
		pos_t       addr;
		logic [7:0] data;
	} name_wr_t;

endpackage

`default_nettype wire

// File: hdl/fln_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/fln_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module fln_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  fln_pkg::eng_job_t job,
	output logic              busy,
	output fln_pkg::ent_rd_t  ent_rd,
	input  logic [7:0]        ent_data,
	output fln_pkg::name_rd_t name_rd,
	input  logic [7:0]        name_data,
	output fln_pkg::name_wr_t name_wr
);

	import fln_pkg::*;

	eng_state_t state_q, state_d;
	pos_t       cnt_q, cnt_d;
	logic       bank_q;
	pos_t       base_q;
	pos_t       count_q;
	logic       dot_q;
	logic [3:0] dot_pos_q;
	logic [3:0] wptr_q, wptr_d;

	logic       issue;
	pos_t       issue_addr;

	logic       wr_vld_s1;
	eng_state_t wr_op_s1;
	pos_t       wr_addr_s1;
	logic [3:0] wr_idx_s1;

	logic       ext;

	// Hold the job parameters for the whole sweep
	always_ff @(posedge clk) begin
		if (job.go && state_q == ENG_IDLE) begin
			bank_q    <= job.bank;
			base_q    <= job.base;
			count_q   <= job.count;
			dot_q     <= job.dot;
			dot_pos_q <= job.dot_pos;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Issue at most one memory read per step and advance
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ent_rd     = '0;
		name_rd    = '0;
		issue      = 1'b0;
		issue_addr = '0;
		case (state_q)
			ENG_IDLE: begin
				if (job.go) begin
					state_d = job.op;
					cnt_d   = '0;
				end
			end
			ENG_LONG: begin
				ent_rd.en   = 1'b1;
				ent_rd.addr = {bank_q, CHAR_OFFSETS[cnt_q[3:0]]};
				issue       = 1'b1;
				issue_addr  = base_q + cnt_q;
				cnt_d       = cnt_q + 8'd1;
				if (cnt_q == pos_t'(CHARS_PER_ENTRY - 1)) begin
					state_d = ENG_IDLE;
				end
			end
			ENG_MOVE: begin
				name_rd.en   = 1'b1;
				name_rd.addr = base_q + cnt_q;
				issue        = 1'b1;
				issue_addr   = cnt_q;
				cnt_d        = cnt_q + 8'd1;
				if (cnt_q == count_q - 8'd1) begin
					state_d = ENG_IDLE;
				end
			end
			ENG_SHORT: begin
				// The final step reads nothing and places the dot
				ent_rd.en   = (cnt_q[3:0] != SHORT_NAME_BYTES);
				ent_rd.addr = {bank_q, cnt_q[4:0]};
				issue       = 1'b1;
				cnt_d       = cnt_q + 8'd1;
				if (cnt_q[3:0] == SHORT_NAME_BYTES) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	// Write stage: read data arrives in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		wr_op_s1   <= state_q;
		wr_addr_s1 <= issue_addr;
		wr_idx_s1  <= cnt_q[3:0];
	end

	always_ff @(posedge clk) begin
		wptr_q <= wptr_d;
	end

	assign ext = (wr_idx_s1 >= SHORT_EXT_START) && dot_q;

	// Drive the name-store write port
	always_comb begin
		name_wr = '0;
		wptr_d  = wptr_q;
		if (job.go && state_q == ENG_IDLE) begin
			wptr_d = '0;
		end
		if (wr_vld_s1) begin
			case (wr_op_s1)
				ENG_LONG: begin
					name_wr.en   = 1'b1;
					name_wr.addr = wr_addr_s1;
					name_wr.data = ent_data;
				end
				ENG_MOVE: begin
					name_wr.en   = 1'b1;
					name_wr.addr = wr_addr_s1;
					name_wr.data = name_data;
				end
				ENG_SHORT: begin
					if (wr_idx_s1 == SHORT_NAME_BYTES) begin
						name_wr.en   = dot_q;
						name_wr.addr = pos_t'(dot_pos_q);
						name_wr.data = CH_DOT;
					end else begin
						name_wr.en   = (ent_data != CH_SPACE);
						name_wr.addr = pos_t'(wptr_q) + pos_t'(ext);
						name_wr.data = ent_data;
						if (ent_data != CH_SPACE) begin
							wptr_d = wptr_q + 4'd1;
						end
					end
				end
				default: begin
					name_wr = '0;
				end
			endcase
		end
	end

	assign busy = (state_q != ENG_IDLE) || wr_vld_s1;

	// A move never reads the entry it writes in the same cycle
	a_move_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		name_rd.en && name_wr.en |-> name_rd.addr != name_wr.addr)
		else $error("name store read and write collide");

	// A new job only arrives once the previous sweep has drained
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.go |-> !busy)
		else $error("engine job started while busy");

endmodule

`default_nettype wire

// File: hdl/fat_long_name_directory_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// FAT long-name directory parser.
// Input channel (in_valid/in_ready): action 0 feeds one directory byte,
// action 1 asks for one character of the current name by char_index.
// Output channel (out_valid/out_ready): found long name, found short name,
// end of directory, or one name character.
// Directory bytes transfer at one per cycle. The byte that closes a 32-byte
// entry is held off while the name-store engine still works on the previous
// entry: copying a long-name entry's characters, writing a short name, or,
// after a long name is reported, moving it through the single write port of
// the name store. Character reads are held off while that engine runs, then
// transfer one per cycle while the receiver keeps up.
// A result passes through the result stage, which waits for the registered
// name-store read, and then the output register.
// A stalled receiver fills the output register and then the stage before it;
// the input keeps taking bytes that close no entry.
// Reset clears the entry position and the chain state. The name store gets
// no clearing pass: characters never written read as whatever it holds.
module fat_long_name_directory_parser #(
	parameter int NAME_STORE_LEN = 130
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  stream_byte,
	input  logic [7:0]  char_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  name_length,
	output logic [7:0]  attributes,
	output logic [31:0] file_size,
	output logic [7:0]  name_char
);

	import fln_pkg::*;

	localparam int   NAW   = $clog2(NAME_STORE_LEN);
	localparam pos_t LEN_P = pos_t'(NAME_STORE_LEN);
	localparam pos_t CPE_P = pos_t'(CHARS_PER_ENTRY);

	// Entry gathering
	logic [4:0] pos_q;
	logic       wbank_q;
	logic [7:0] first_q, attr_q, ck13_q, sz0_q, sz1_q, sz2_q, sum_q;
	logic [3:0] sl_q, dot_pos_q;
	logic       dot_q;
	logic       nonsp;

	// Chain and name state
	logic       act_q, act_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] cks_q, cks_d;
	pos_t       ns_q, ns_d;
	logic       long_q, long_d;
	logic [3:0] slen_q, slen_d;
	pos_t       cur_len;

	// Handshake
	logic in_acc, fin_acc, rd_acc;
	logic s1_can_load, out_can_load, s1_adv;

	// Result of a closing entry
	logic        res_vld;
	logic [1:0]  res_kind;
	pos_t        res_len;
	logic [7:0]  res_attr;
	logic [31:0] res_size;

	// Result stage and output register
	logic        vld_s1, hit_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  len_s1, attr_s1;
	logic [31:0] size_s1;
	logic        out_vld_q;
	logic [1:0]  kind_q;
	logic [7:0]  len_q, attr_q2, char_q;
	logic [31:0] size_q;

	// Engine and memories
	eng_job_t   job;
	logic       eng_busy;
	ent_rd_t    ent_rd;
	name_rd_t   eng_nrd;
	name_wr_t   name_wr;
	logic [7:0] ent_data, name_data;
	logic       nrd_en;
	logic [NAW-1:0] nrd_addr;

	assign out_can_load = !out_vld_q || out_ready;
	assign s1_can_load  = !vld_s1 || out_can_load;
	assign s1_adv       = vld_s1 && out_can_load;

	// Bytes that close no entry always transfer
	assign in_ready = (!action && pos_q != ENTRY_LAST) || (!eng_busy && s1_can_load);
	assign in_acc   = in_valid && in_ready;
	assign fin_acc  = in_acc && !action && pos_q == ENTRY_LAST;
	assign rd_acc   = in_acc && action;
	assign nonsp    = (stream_byte != CH_SPACE);

	// Advance the entry position and switch banks at each closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			wbank_q <= 1'b0;
		end else if (in_acc && !action) begin
			pos_q <= pos_q + 5'd1;
			if (pos_q == ENTRY_LAST) begin
				wbank_q <= !wbank_q;
			end
		end
	end

	// Capture header fields, running checksum and short-name length
	always_ff @(posedge clk) begin
		if (in_acc && !action) begin
			if (pos_q == '0) begin
				first_q <= stream_byte;
				sum_q   <= stream_byte;
				sl_q    <= 4'(nonsp);
			end else if (pos_q <= POS_SHORT_LAST) begin
				sum_q <= {sum_q[0], sum_q[7:1]} + stream_byte;
				if (pos_q == POS_EXT) begin
					dot_pos_q <= sl_q;
					dot_q     <= nonsp;
					sl_q      <= sl_q + (nonsp ? 4'd2 : 4'd0);
				end else begin
					sl_q <= sl_q + 4'(nonsp);
				end
			end
			case (pos_q)
				POS_ATTR:     attr_q <= stream_byte;
				POS_CHECKSUM: ck13_q <= stream_byte;
				POS_SIZE0:    sz0_q  <= stream_byte;
				POS_SIZE1:    sz1_q  <= stream_byte;
				POS_SIZE2:    sz2_q  <= stream_byte;
				default:      ;
			endcase
		end
	end

	// Decide what a closing entry does to the chain and the name
	always_comb begin
		act_d    = act_q;
		seq_d    = seq_q;
		cks_d    = cks_q;
		ns_d     = ns_q;
		long_d   = long_q;
		slen_d   = slen_q;
		job      = '0;
		job.op   = ENG_IDLE;
		job.bank = wbank_q;
		res_vld  = 1'b0;
		res_kind = KIND_END;
		res_len  = '0;
		res_attr = '0;
		res_size = '0;
		if (fin_acc) begin
			if (attr_q[3:0] == ATTR_LFN) begin
				if (!act_q) begin
					// Start a chain and place its first characters at the top
					if (first_q[7:5] == SEQ_START) begin
						seq_d    = {3'b000, first_q[4:0]};
						cks_d    = ck13_q;
						act_d    = 1'b1;
						long_d   = 1'b1;
						ns_d     = LEN_P - CPE_P;
						job.go   = 1'b1;
						job.op   = ENG_LONG;
						job.base = LEN_P - CPE_P;
					end
				end else begin
					seq_d = seq_q - 8'd1;
					if (first_q != seq_d || cks_q != ck13_q) begin
						act_d = 1'b0;
					end else if (ns_q >= CPE_P) begin
						ns_d     = ns_q - CPE_P;
						job.go   = 1'b1;
						job.op   = ENG_LONG;
						job.base = ns_q - CPE_P;
					end
				end
			end else if (!attr_q[3] && first_q != MARK_DELETED && first_q != MARK_FREE &&
					first_q != CH_DOT) begin
				act_d    = 1'b0;
				res_vld  = 1'b1;
				res_attr = attr_q;
				res_size = {stream_byte, sz2_q, sz1_q, sz0_q};
				if (act_q && sum_q == cks_q && seq_q == 8'd1) begin
					// Report the long name and move it to the bottom of the store
					res_kind = KIND_LONG;
					res_len  = LEN_P - ns_q;
					long_d   = 1'b1;
					if (ns_q != '0 && ns_q != LEN_P) begin
						job.go    = 1'b1;
						job.op    = ENG_MOVE;
						job.base  = ns_q;
						job.count = LEN_P - ns_q;
					end
				end else begin
					res_kind    = KIND_SHORT;
					res_len     = pos_t'(sl_q);
					long_d      = 1'b0;
					slen_d      = sl_q;
					job.go      = 1'b1;
					job.op      = ENG_SHORT;
					job.dot     = dot_q;
					job.dot_pos = dot_pos_q;
				end
			end else begin
				act_d = 1'b0;
				if (first_q == MARK_FREE) begin
					long_d   = 1'b0;
					slen_d   = '0;
					res_vld  = 1'b1;
					res_kind = KIND_END;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			seq_q  <= '0;
			cks_q  <= '0;
			ns_q   <= LEN_P;
			long_q <= 1'b0;
			slen_q <= '0;
		end else begin
			act_q  <= act_d;
			seq_q  <= seq_d;
			cks_q  <= cks_d;
			ns_q   <= ns_d;
			long_q <= long_d;
			slen_q <= slen_d;
		end
	end

	assign cur_len = long_q ? (LEN_P - ns_q) : pos_t'(slen_q);

	// Entry memory: two banks, one filling while the engine reads the other
	fln_ram #(
		.WIDTH(8),
		.DEPTH(64)
	) u_entry_ram (
		.clk  (clk),
		.we   (in_acc && !action),
		.waddr({wbank_q, pos_q}),
		.wdata(stream_byte),
		.re   (ent_rd.en),
		.raddr(ent_rd.addr),
		.rdata(ent_data)
	);

	// Name store read port: the engine's move or a character read
	assign nrd_en   = eng_nrd.en || rd_acc;
	assign nrd_addr = eng_nrd.en ? eng_nrd.addr[NAW-1:0] : char_index[NAW-1:0];

	fln_ram #(
		.WIDTH(8),
		.DEPTH(NAME_STORE_LEN)
	) u_name_ram (
		.clk  (clk),
		.we   (name_wr.en),
		.waddr(name_wr.addr[NAW-1:0]),
		.wdata(name_wr.data),
		.re   (nrd_en),
		.raddr(nrd_addr),
		.rdata(name_data)
	);

	fln_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.busy     (eng_busy),
		.ent_rd   (ent_rd),
		.ent_data (ent_data),
		.name_rd  (eng_nrd),
		.name_data(name_data),
		.name_wr  (name_wr)
	);

	// Result stage: waits for the registered name-store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rd_acc || res_vld) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			kind_s1 <= KIND_CHAR;
			len_s1  <= '0;
			attr_s1 <= '0;
			size_s1 <= '0;
			hit_s1  <= (char_index < cur_len);
		end else if (res_vld) begin
			kind_s1 <= res_kind;
			len_s1  <= res_len;
			attr_s1 <= res_attr;
			size_s1 <= res_size;
			hit_s1  <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_can_load) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			kind_q  <= kind_s1;
			len_q   <= len_s1;
			attr_q2 <= attr_s1;
			size_q  <= size_s1;
			char_q  <= hit_s1 ? name_data : 8'd0;
		end
	end

	assign out_valid   = out_vld_q;
	assign kind        = kind_q;
	assign name_length = len_q;
	assign attributes  = attr_q2;
	assign file_size   = size_q;
	assign name_char   = char_q;

	// A pending character read must not see the engine rewrite the store
	a_read_engine_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && kind_s1 == KIND_CHAR |-> !eng_busy)
		else $error("character read pending while engine busy");

	a_name_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		ns_q <= LEN_P)
		else $error("name start beyond store");

	a_short_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		fin_acc && !long_d |=> slen_q <= SHORT_MAX_LEN)
		else $error("short name length out of range");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

	import fln_pkg::*;

	localparam int NAME_LEN       = 130;
	localparam int NAME_CHARS     = 13;
	localparam int RANDOM_ITEMS   = 150;
	localparam int PRESSURE_AFTER = 10;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic       OP_BYTE     = 1'b0;
	localparam logic       OP_READ     = 1'b1;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] DOT_CHAR    = 8'h2E;
	localparam logic [7:0] FREE_MARK   = 8'h00;
	localparam logic [7:0] DEL_MARK    = 8'hE5;
	localparam logic [3:0] LFN_NIBBLE  = 4'hF;
	localparam logic [2:0] START_BITS  = 3'b010;
	localparam int         LFN_OFFSETS [NAME_CHARS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

	typedef enum int {
		CHAIN_INTACT,
		CHAIN_BAD_SEQ,
		CHAIN_BAD_SUM,
		CHAIN_BAD_SHORT
	} chain_fault_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  len;
		logic [7:0]  attr;
		logic [31:0] size;
		logic [7:0]  ch;
	} name_report_t;

	// Track the parser state per transfer and match reports in order
	class dir_scoreboard;
		logic [7:0]   entry [32];
		logic [7:0]   store [NAME_LEN + 1];
		logic [4:0]   pos;
		bit           chain;
		logic [7:0]   seq_left;
		logic [7:0]   chain_sum;
		logic [7:0]   start;
		bit           is_long;
		logic [3:0]   short_len;
		name_report_t pending_reports [$];
		int           errors;

		function new();
			foreach (store[i]) store[i] = 8'h00;
			pos       = '0;
			chain     = 1'b0;
			seq_left  = '0;
			chain_sum = '0;
			start     = 8'(NAME_LEN);
			is_long   = 1'b0;
			short_len = '0;
			errors    = 0;
		endfunction

		function int unsigned name_len();
			return is_long ? NAME_LEN - start : short_len;
		endfunction

		function void note_transfer(logic act, logic [7:0] b, logic [7:0] idx);
			name_report_t r;
			r = '0;
			if (act == OP_READ) begin
				r.kind = KIND_CHAR;
				if (idx < name_len() && idx < NAME_LEN)
					r.ch = store[idx];
				pending_reports.push_back(r);
			end else begin
				entry[pos] = b;
				pos = pos + 5'd1;
				if (pos == 5'd0)
					close_entry();
			end
		endfunction

		// Classify the finished 32-byte entry
		function void close_entry();
			logic [7:0]   first;
			logic [7:0]   attr;
			logic [7:0]   csum;
			name_report_t r;
			int           span;
			int           n;
			bit           use_long;
			first = entry[0];
			attr  = entry[11];
			r     = '0;
			if (attr[3:0] == LFN_NIBBLE) begin
				if (!chain) begin
					if (first[7:5] != START_BITS)
						return;
					seq_left  = {3'b000, first[4:0]};
					chain_sum = entry[13];
					chain     = 1'b1;
					start     = 8'(NAME_LEN);
					is_long   = 1'b1;
				end else begin
					seq_left = seq_left - 8'd1;
					if (first != seq_left || chain_sum != entry[13]) begin
						chain = 1'b0;
						return;
					end
				end
				// place characters backwards; a full store only counts the sequence
				if (start >= NAME_CHARS) begin
					start = start - 8'(NAME_CHARS);
					for (int i = 0; i < NAME_CHARS; i++)
						store[start + i] = entry[LFN_OFFSETS[i]];
				end
				return;
			end
			if (!attr[3] && first != DEL_MARK && first != FREE_MARK && first != DOT_CHAR) begin
				csum = 8'h00;
				for (int i = 0; i < 11; i++)
					csum = {csum[0], csum[7:1]} + entry[i];
				use_long = chain && csum == chain_sum && seq_left == 8'd1;
				chain  = 1'b0;
				r.attr = attr;
				r.size = {entry[31], entry[30], entry[29], entry[28]};
				if (use_long) begin
					span = NAME_LEN - start;
					for (int i = 0; i < span; i++)
						store[i] = store[start + i];
					is_long = 1'b1;
					r.kind  = KIND_LONG;
					r.len   = 8'(span);
				end else begin
					// format 8.3: drop spaces, dot before a non-space extension
					n = 0;
					for (int i = 0; i < 11; i++) begin
						if (entry[i] != SPACE_CHAR) begin
							if (i == 8) begin
								store[n] = DOT_CHAR;
								n++;
							end
							store[n] = entry[i];
							n++;
						end
					end
					short_len = 4'(n);
					is_long   = 1'b0;
					r.kind    = KIND_SHORT;
					r.len     = 8'(n);
				end
				pending_reports.push_back(r);
				return;
			end
			chain = 1'b0;
			if (first == FREE_MARK) begin
				is_long   = 1'b0;
				short_len = '0;
				r.kind    = KIND_END;
				pending_reports.push_back(r);
			end
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_report(logic [1:0] k, logic [7:0] len, logic [7:0] attr,
				logic [31:0] size, logic [7:0] ch);
			name_report_t e;
			if (pending_reports.size() == 0) begin
				$error("result with nothing pending: kind %0d", k);
				errors++;
				return;
			end
			e = pending_reports.pop_front();
			check_field("kind", e.kind, k);
			check_field("name_length", e.len, len);
			check_field("attributes", e.attr, attr);
			check_field("file_size", e.size, size);
			check_field("name_char", e.ch, ch);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [7:0]  stream_byte;
	logic [7:0]  char_index;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  name_length;
	logic [7:0]  attributes;
	logic [31:0] file_size;
	logic [7:0]  name_char;

	dir_scoreboard sb;
	logic [7:0]    ent [32];
	bit            steady;
	int            items_sent;
	int            results_seen;

	fat_long_name_directory_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.stream_byte (stream_byte),
		.char_index  (char_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.name_length (name_length),
		.attributes  (attributes),
		.file_size   (file_size),
		.name_char   (name_char)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_transfer(action, stream_byte, char_index);
		if (out_valid && out_ready) begin
			sb.check_report(kind, name_length, attributes, file_size, name_char);
			results_seen++;
		end
	end

	// Offer one item after a random gap and hold it until the transfer
	task automatic offer(input logic a, input logic [7:0] b, input logic [7:0] idx);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= a;
		stream_byte <= b;
		char_index  <= idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic stream_entry();
		for (int i = 0; i < 32; i++)
			offer(OP_BYTE, ent[i], 8'($urandom));
	endtask

	// Read characters, mostly inside the current name
	task automatic read_chars(input int count);
		int unsigned len;
		int unsigned idx;
		for (int c = 0; c < count; c++) begin
			len = sb.name_len();
			idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, len) : $urandom_range(0, NAME_LEN);
			offer(OP_READ, 8'($urandom), 8'(idx));
		end
	endtask

	function automatic void fill_random();
		for (int i = 0; i < 32; i++)
			ent[i] = 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(8'h21, 8'hFF));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic void name_entry(input string s, input logic [7:0] attr,
			input logic [31:0] size);
		fill_random();
		for (int i = 0; i < 11; i++)
			ent[i] = s[i];
		ent[11] = attr;
		{ent[31], ent[30], ent[29], ent[28]} = size;
	endfunction

	// Random 8.3 name, padded with spaces, sometimes with a space inside
	function automatic void fill_short(input logic [7:0] attr);
		int base_len;
		int ext_len;
		fill_random();
		base_len = $urandom_range(1, 8);
		ext_len  = $urandom_range(0, 3);
		for (int i = 0; i < 8; i++)
			ent[i] = (i < base_len) ? pick_char() : SPACE_CHAR;
		for (int i = 0; i < 3; i++)
			ent[8 + i] = (i < ext_len) ? pick_char() : SPACE_CHAR;
		if ($urandom_range(0, 7) == 0)
			ent[$urandom_range(0, 10)] = SPACE_CHAR;
		if (ent[0] == DEL_MARK || ent[0] == DOT_CHAR)
			ent[0] = "A";
		ent[11] = attr;
	endfunction

	function automatic void lfn_fill(input logic [7:0] first, input logic [7:0] csum);
		fill_random();
		ent[0]  = first;
		ent[11] = {4'($urandom), LFN_NIBBLE};
		ent[13] = csum;
	endfunction

	function automatic logic [7:0] short_sum();
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < 11; i++)
			s = {s[0], s[7:1]} + ent[i];
		return s;
	endfunction

	// Send a long-name chain for the short entry in ent, then the entry itself
	task automatic chained_name(input int n, input chain_fault_t fault, input int at);
		logic [7:0] held [32];
		logic [7:0] csum;
		held = ent;
		csum = short_sum();
		if (fault == CHAIN_BAD_SHORT)
			csum = csum ^ 8'(1 << $urandom_range(0, 7));
		for (int k = n; k >= 1; k--) begin
			lfn_fill((k == n) ? {START_BITS, 5'(k)} : 8'(k), csum);
			if (k == at && k != n) begin
				if (fault == CHAIN_BAD_SEQ)
					ent[0] = 8'(k + 1 + $urandom_range(0, 200));
				else if (fault == CHAIN_BAD_SUM)
					ent[13] = csum ^ 8'(1 << $urandom_range(0, 7));
			end
			stream_entry();
		end
		ent = held;
		stream_entry();
	endtask

	// Stall the receiver at random, with one long hold-off
	initial begin : receiver
		int stall;
		bit held_off;
		out_ready = 1'b0;
		held_off  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= PRESSURE_AFTER) begin
				// hold off long enough to fill the block and stall its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 3);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// End the run when nothing transfers for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] keep [32];
		logic [7:0] csum;
		int         base;
		int         sel;
		int         n;
		sb           = new();
		in_valid     = 1'b0;
		action       = OP_BYTE;
		stream_byte  = 8'h00;
		char_index   = 8'h00;
		arst_n       = 1'b0;
		steady       = 1'b0;
		items_sent   = 0;
		results_seen = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reads with no name held
		offer(OP_READ, 8'hFF, 8'd0);
		offer(OP_READ, 8'h00, 8'd130);

		// plain 8.3 names: a padded base with a dot, and twelve characters
		name_entry("README  TXT", 8'h21, 32'hFFFF_FFFF);
		stream_entry();
		offer(OP_READ, 8'h00, 8'd0);
		offer(OP_READ, 8'h00, 8'd9);
		offer(OP_READ, 8'h00, 8'd10);
		name_entry("ABCDEFGHIJK", 8'h10, 32'h0000_0000);
		stream_entry();
		offer(OP_READ, 8'hFF, 8'd11);
		offer(OP_READ, 8'hFF, 8'd12);

		// long names back to back: two entries, then a full store and one entry past it
		steady = 1'b1;
		name_entry("LONGNA~1TXT", 8'h20, 32'h1234_5678);
		chained_name(2, CHAIN_INTACT, 0);
		offer(OP_READ, 8'h00, 8'd0);
		offer(OP_READ, 8'h00, 8'd25);
		offer(OP_READ, 8'h00, 8'd26);
		offer(OP_READ, 8'h00, 8'd130);
		name_entry("OVERFL~1   ", 8'h00, 32'h0000_00FF);
		chained_name(11, CHAIN_INTACT, 0);
		offer(OP_READ, 8'h00, 8'd0);
		offer(OP_READ, 8'h00, 8'd129);
		steady = 1'b0;

		// long entries with no chain, one of them with a free mark
		lfn_fill(8'h01, 8'h55);
		stream_entry();
		lfn_fill(FREE_MARK, 8'h55);
		stream_entry();

		// broken chains fall back to the short name
		name_entry("BROKEN  SEQ", 8'h20, 32'h0000_1000);
		chained_name(2, CHAIN_BAD_SEQ, 1);
		name_entry("BROKEN  SUM", 8'h01, 32'h0000_2000);
		chained_name(2, CHAIN_BAD_SUM, 1);
		name_entry("MISMAT~1DAT", 8'h02, 32'h0000_3000);
		chained_name(1, CHAIN_BAD_SHORT, 0);

		// sequence zero wraps to 255 and never reaches one
		name_entry("WRAP    ZZZ", 8'h20, 32'h0000_0042);
		csum = short_sum();
		keep = ent;
		lfn_fill({START_BITS, 5'd0}, csum);
		stream_entry();
		lfn_fill(8'hFF, csum);
		stream_entry();
		ent = keep;
		stream_entry();

		// deleted entry between chain and name clears the chain
		name_entry("AFTERDELTXT", 8'h20, 32'h0000_0077);
		csum = short_sum();
		keep = ent;
		lfn_fill({START_BITS, 5'd1}, csum);
		stream_entry();
		ent    = keep;
		ent[0] = DEL_MARK;
		stream_entry();
		ent = keep;
		stream_entry();

		// free entry ends the directory
		fill_random();
		ent[0]  = FREE_MARK;
		ent[11] = 8'h20;
		stream_entry();
		offer(OP_READ, 8'h00, 8'd0);

		// random directory: mostly well-formed chains, the rest noise
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 7) == 0);
			sel    = $urandom_range(0, 99);
			if (sel < 45) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
				fill_short(8'($urandom) & 8'hF7);
				chained_name(n, CHAIN_INTACT, 0);
			end else if (sel < 60) begin
				fill_short(8'($urandom) & 8'hF7);
				stream_entry();
			end else if (sel < 72) begin
				n = $urandom_range(2, 4);
				fill_short(8'($urandom) & 8'hF7);
				chained_name(n, chain_fault_t'($urandom_range(1, 3)), $urandom_range(1, n - 1));
			end else if (sel < 82) begin
				fill_short(8'($urandom) & 8'hF7);
				case ($urandom_range(0, 3))
					0: ent[0] = DEL_MARK;
					1: ent[0] = DOT_CHAR;
					2: ent[11] = ent[11] | 8'h08;
					default: begin
						lfn_fill(8'($urandom_range(0, 255)), 8'($urandom));
					end
				endcase
				stream_entry();
			end else if (sel < 87) begin
				fill_random();
				ent[0] = FREE_MARK;
				if (ent[11][3:0] == LFN_NIBBLE)
					ent[11][0] = 1'b0;
				stream_entry();
			end else begin
				fill_random();
				stream_entry();
			end
			read_chars($urandom_range(0, 3));
		end

		// drain
		steady = 1'b0;
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
